>>> src/mps_pkg.sv
// Shared types and constants of the multi-policy process scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

    // One input transaction.
    typedef struct packed {
        logic       kind;
        logic [7:0] proc_id;
        logic [7:0] prio_level;
        logic [7:0] cpu_need;
        logic [7:0] io_need;
        logic       io_request;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0]  running_id;
        logic        preempted;
        logic        io_started;
        logic [4:0]  io_completions;
        logic        finished;
        logic [7:0]  finished_id;
        logic [15:0] finished_wait;
        logic [15:0] finished_turnaround;
    } t_out_item;

    // Scheduling policy codes.
    localparam logic [2:0] MODE_FCFS  = 3'd0;
    localparam logic [2:0] MODE_SJF   = 3'd1;
    localparam logic [2:0] MODE_PSJF  = 3'd2;
    localparam logic [2:0] MODE_PRIO  = 3'd3;
    localparam logic [2:0] MODE_PPRIO = 3'd4;
    localparam logic [2:0] MODE_RR    = 3'd5;

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 8;
    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [2:0] RST_MODE   = MODE_FCFS;
    localparam logic [7:0] RST_SLICE  = 8'd3;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SEL_RUN,
        ST_SEL_RUNK,
        ST_SCAN_Q,
        ST_SCAN_T,
        ST_SCAN_C,
        ST_SEL_DEC,
        ST_SHIFT_R,
        ST_SHIFT_W,
        ST_TAKE_FIN,
        ST_AGE_Q,
        ST_AGE_T,
        ST_AGE_W,
        ST_IO_Q,
        ST_IO_T,
        ST_IO_W,
        ST_RUN_T,
        ST_RUN_W,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic do_arrive;
        logic rd_run;
        logic cap_runkey;
        logic scan_rdt;
        logic scan_cmp;
        logic take_init;
        logic shift_rd;
        logic shift_wr;
        logic take_fin;
        logic idx_clr;
        logic age_rdt;
        logic age_wr;
        logic io_rdt;
        logic io_wr;
        logic io_end;
        logic run_wr;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_kind;
        logic need_sel;
        logic scan_more;
        logic take;
        logic shift_more;
        logic idx_lt_rc;
        logic idx_lt_wc;
        logic run_valid;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> src/mps_ctrl.sv
// Sequencer of the process scheduler: walks one arrival or tick through its phases.
// Depends on mps_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module mps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire mps_pkg::t_stat i_stat,
    output mps_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    mps_pkg::t_state r_state;
    mps_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_kind ? mps_pkg::ST_SEL_RUN : mps_pkg::ST_ARRIVE;
                end
            end
            mps_pkg::ST_ARRIVE:   n_state = mps_pkg::ST_IDLE;
            mps_pkg::ST_SEL_RUN:  n_state = mps_pkg::ST_SEL_RUNK;
            mps_pkg::ST_SEL_RUNK: begin
                n_state = i_stat.need_sel ? mps_pkg::ST_SCAN_Q : mps_pkg::ST_AGE_Q;
            end
            mps_pkg::ST_SCAN_Q:   n_state = mps_pkg::ST_SCAN_T;
            mps_pkg::ST_SCAN_T:   n_state = mps_pkg::ST_SCAN_C;
            mps_pkg::ST_SCAN_C: begin
                n_state = i_stat.scan_more ? mps_pkg::ST_SCAN_Q : mps_pkg::ST_SEL_DEC;
            end
            mps_pkg::ST_SEL_DEC: begin
                n_state = i_stat.take ? mps_pkg::ST_SHIFT_R : mps_pkg::ST_AGE_Q;
            end
            mps_pkg::ST_SHIFT_R: begin
                n_state = i_stat.shift_more ? mps_pkg::ST_SHIFT_W : mps_pkg::ST_TAKE_FIN;
            end
            mps_pkg::ST_SHIFT_W:  n_state = mps_pkg::ST_SHIFT_R;
            mps_pkg::ST_TAKE_FIN: n_state = mps_pkg::ST_AGE_Q;
            mps_pkg::ST_AGE_Q: begin
                n_state = i_stat.idx_lt_rc ? mps_pkg::ST_AGE_T : mps_pkg::ST_IO_Q;
            end
            mps_pkg::ST_AGE_T:    n_state = mps_pkg::ST_AGE_W;
            mps_pkg::ST_AGE_W:    n_state = mps_pkg::ST_AGE_Q;
            mps_pkg::ST_IO_Q: begin
                n_state = i_stat.idx_lt_wc ? mps_pkg::ST_IO_T : mps_pkg::ST_RUN_T;
            end
            mps_pkg::ST_IO_T:     n_state = mps_pkg::ST_IO_W;
            mps_pkg::ST_IO_W:     n_state = mps_pkg::ST_IO_Q;
            mps_pkg::ST_RUN_T: begin
                n_state = i_stat.run_valid ? mps_pkg::ST_RUN_W : mps_pkg::ST_OUT;
            end
            mps_pkg::ST_RUN_W:    n_state = mps_pkg::ST_OUT;
            mps_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = mps_pkg::ST_IDLE;
                end
            end
            default:              n_state = mps_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != mps_pkg::ST_IDLE);
        case (r_state)
            mps_pkg::ST_IDLE:     o_cmd.latch_in   = i_in_valid;
            mps_pkg::ST_ARRIVE:   o_cmd.do_arrive  = 1'b1;
            mps_pkg::ST_SEL_RUN:  o_cmd.rd_run     = 1'b1;
            mps_pkg::ST_SEL_RUNK: o_cmd.cap_runkey = 1'b1;
            mps_pkg::ST_SCAN_Q:   o_cmd            = '0;
            mps_pkg::ST_SCAN_T:   o_cmd.scan_rdt   = 1'b1;
            mps_pkg::ST_SCAN_C:   o_cmd.scan_cmp   = 1'b1;
            mps_pkg::ST_SEL_DEC: begin
                o_cmd.take_init = i_stat.take;
                o_cmd.idx_clr   = !i_stat.take;
            end
            mps_pkg::ST_SHIFT_R:  o_cmd.shift_rd   = 1'b1;
            mps_pkg::ST_SHIFT_W:  o_cmd.shift_wr   = 1'b1;
            mps_pkg::ST_TAKE_FIN: o_cmd.take_fin   = 1'b1;
            mps_pkg::ST_AGE_Q:    o_cmd.idx_clr    = !i_stat.idx_lt_rc;
            mps_pkg::ST_AGE_T:    o_cmd.age_rdt    = 1'b1;
            mps_pkg::ST_AGE_W:    o_cmd.age_wr     = 1'b1;
            mps_pkg::ST_IO_Q:     o_cmd.io_end     = !i_stat.idx_lt_wc;
            mps_pkg::ST_IO_T:     o_cmd.io_rdt     = 1'b1;
            mps_pkg::ST_IO_W:     o_cmd.io_wr      = 1'b1;
            mps_pkg::ST_RUN_T:    o_cmd.rd_run     = i_stat.run_valid;
            mps_pkg::ST_RUN_W:    o_cmd.run_wr     = 1'b1;
            mps_pkg::ST_OUT:      o_cmd.out_load   = i_stat.out_free;
            default:              o_cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/mps_dpath.sv
// Datapath of the process scheduler: process table, ready and wait queues,
// configuration, counters and the result register. Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mps_dpath #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mps_pkg::t_in_item                 i_in_data,
    input  wire logic                              i_out_stall,
    input  wire logic                              i_cfg_valid,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire mps_pkg::t_cmd                     i_cmd,
    output mps_pkg::t_stat                         o_stat,
    output logic                                   o_out_valid,
    output mps_pkg::t_out_item                     o_out_data,
    output logic                                   o_cfg_ready
);

    localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] N_C = CW'(MAX_PROCS);

    // One process table entry.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [7:0]  cpu;
        logic [7:0]  io;
        logic [15:0] arr;
        logic [15:0] wait_cnt;
        logic [15:0] tat_cnt;
    } t_entry;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Memories and their registered read data.
    t_entry          r_tbl [MAX_PROCS];
    logic [SW-1:0]   r_rq  [MAX_PROCS];
    logic [SW-1:0]   r_wq  [MAX_PROCS];
    t_entry          r_tbl_q;
    logic [SW-1:0]   r_rq_q;
    logic [SW-1:0]   r_wq_q;

    // Control and working registers.
    logic [2:0]           r_mode, n_mode;
    logic [7:0]           r_slice, n_slice;
    mps_pkg::t_in_item    r_in, n_in;
    logic [CW-1:0]        r_rc, n_rc, r_wc, n_wc;
    logic                 r_run_valid, n_run_valid;
    logic [SW-1:0]        r_run_slot, n_run_slot;
    logic [7:0]           r_slice_used, n_slice_used;
    logic [15:0]          r_tick, n_tick;
    logic [MAX_PROCS-1:0] r_free, n_free;
    logic [CW-1:0]        r_idx, n_idx, r_keep, n_keep, r_best_pos, n_best_pos;
    logic [4:0]           r_done, n_done;
    logic [SW-1:0]        r_cur_slot, n_cur_slot, r_best_slot, n_best_slot;
    logic [7:0]           r_best_key, n_best_key, r_run_key, n_run_key;
    logic [15:0]          r_best_arr, n_best_arr, r_run_arr, n_run_arr;
    mps_pkg::t_out_item   r_res, n_res, r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    // Policy decode.
    logic [2:0] m_eff;
    logic       use_prio, preempt, best_mode, rr;
    always_comb begin
        m_eff     = (r_mode > mps_pkg::MODE_RR) ? mps_pkg::MODE_FCFS : r_mode;
        use_prio  = (m_eff == mps_pkg::MODE_PRIO) || (m_eff == mps_pkg::MODE_PPRIO);
        preempt   = (m_eff == mps_pkg::MODE_PSJF) || (m_eff == mps_pkg::MODE_PPRIO);
        rr        = (m_eff == mps_pkg::MODE_RR);
        best_mode = !((m_eff == mps_pkg::MODE_FCFS) || rr);
    end

    // Comparisons for selection.
    logic [7:0]    cur_key;
    logic          cur_better, best_better_run;
    logic [CW-1:0] idx_p1, limit, rc_m1;
    always_comb begin
        cur_key    = use_prio ? r_tbl_q.prio : r_tbl_q.cpu;
        cur_better = (cur_key < r_best_key) ||
                     ((cur_key == r_best_key) && (r_tbl_q.arr < r_best_arr));
        best_better_run = (r_best_key < r_run_key) ||
                          ((r_best_key == r_run_key) && (r_best_arr < r_run_arr));
        idx_p1 = r_idx + 1'b1;
        rc_m1  = r_rc - 1'b1;
        limit  = best_mode ? r_rc : CW'(1);
    end

    // Lowest free slot.
    logic [SW-1:0] free_slot;
    logic          arr_ok;
    always_comb begin
        free_slot = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_slot = SW'(i);
            end
        end
        arr_ok = (r_in.proc_id != 8'd0) && (|r_free) && (r_rc < N_C);
    end

    // Updated entries for arrival, ageing, I/O countdown and running.
    t_entry age_e, io_e, run_e, new_e;
    logic   io_fin, run_fin, run_io;
    always_comb begin
        age_e          = r_tbl_q;
        age_e.wait_cnt = inc16(r_tbl_q.wait_cnt);
        age_e.tat_cnt  = inc16(r_tbl_q.tat_cnt);
        io_e           = r_tbl_q;
        io_e.tat_cnt   = inc16(r_tbl_q.tat_cnt);
        io_e.io        = (r_tbl_q.io != 8'd0) ? r_tbl_q.io - 8'd1 : 8'd0;
        io_fin         = (io_e.io == 8'd0);
        run_e          = r_tbl_q;
        run_e.tat_cnt  = inc16(r_tbl_q.tat_cnt);
        run_e.cpu      = (r_tbl_q.cpu != 8'd0) ? r_tbl_q.cpu - 8'd1 : 8'd0;
        run_fin        = (run_e.cpu == 8'd0);
        run_io         = !run_fin && (r_tbl_q.io != 8'd0) && r_in.io_request;
        new_e          = '{id: r_in.proc_id, prio: r_in.prio_level, cpu: r_in.cpu_need,
                           io: r_in.io_need, arr: r_tick, wait_cnt: 16'd0, tat_cnt: 16'd0};
    end

    // Memory port selection.
    logic          tbl_we, rq_we, wq_we;
    logic [SW-1:0] tbl_wa, tbl_ra, rq_wa, rq_ra, rq_wd, wq_wa, wq_ra, wq_wd;
    t_entry        tbl_wd;
    always_comb begin
        tbl_ra = r_run_slot;
        if (i_cmd.scan_rdt || i_cmd.age_rdt) begin
            tbl_ra = r_rq_q;
        end else if (i_cmd.io_rdt) begin
            tbl_ra = r_wq_q;
        end
        rq_ra = i_cmd.shift_rd ? idx_p1[SW-1:0] : r_idx[SW-1:0];
        wq_ra = r_idx[SW-1:0];

        tbl_we = 1'b0;
        tbl_wa = r_cur_slot;
        tbl_wd = age_e;
        if (i_cmd.do_arrive) begin
            tbl_we = arr_ok;
            tbl_wa = free_slot;
            tbl_wd = new_e;
        end else if (i_cmd.age_wr) begin
            tbl_we = 1'b1;
        end else if (i_cmd.io_wr) begin
            tbl_we = 1'b1;
            tbl_wd = io_e;
        end else if (i_cmd.run_wr) begin
            tbl_we = 1'b1;
            tbl_wa = r_run_slot;
            tbl_wd = run_e;
        end

        rq_we = 1'b0;
        rq_wa = r_rc[SW-1:0];
        rq_wd = r_cur_slot;
        if (i_cmd.do_arrive) begin
            rq_we = arr_ok;
            rq_wd = free_slot;
        end else if (i_cmd.shift_wr) begin
            rq_we = 1'b1;
            rq_wa = r_idx[SW-1:0];
            rq_wd = r_rq_q;
        end else if (i_cmd.take_fin) begin
            rq_we = r_run_valid;
            rq_wa = rc_m1[SW-1:0];
            rq_wd = r_run_slot;
        end else if (i_cmd.io_wr) begin
            rq_we = io_fin && (r_rc < N_C);
        end

        wq_we = 1'b0;
        wq_wa = r_keep[SW-1:0];
        wq_wd = r_cur_slot;
        if (i_cmd.io_wr) begin
            wq_we = !io_fin;
        end else if (i_cmd.run_wr) begin
            wq_we = run_io && (r_wc < N_C);
            wq_wa = r_wc[SW-1:0];
            wq_wd = r_run_slot;
        end
    end

    // Memories with one write and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_wa] <= tbl_wd;
        end
        r_tbl_q <= r_tbl[tbl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rq_we) begin
            r_rq[rq_wa] <= rq_wd;
        end
        r_rq_q <= r_rq[rq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            r_wq[wq_wa] <= wq_wd;
        end
        r_wq_q <= r_wq[wq_ra];
    end

    // Next values of the registers.
    always_comb begin
        n_mode       = r_mode;
        n_slice      = r_slice;
        n_in         = r_in;
        n_rc         = r_rc;
        n_wc         = r_wc;
        n_run_valid  = r_run_valid;
        n_run_slot   = r_run_slot;
        n_slice_used = r_slice_used;
        n_tick       = r_tick;
        n_free       = r_free;
        n_idx        = r_idx;
        n_keep       = r_keep;
        n_best_pos   = r_best_pos;
        n_done       = r_done;
        n_cur_slot   = r_cur_slot;
        n_best_slot  = r_best_slot;
        n_best_key   = r_best_key;
        n_run_key    = r_run_key;
        n_best_arr   = r_best_arr;
        n_run_arr    = r_run_arr;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;

        // Configuration writes.
        if (i_cfg_valid) begin
            if (i_cfg_index == mps_pkg::CFG_POLICY) begin
                n_mode = i_cfg_data[2:0];
            end else if (i_cfg_index == mps_pkg::CFG_SLICE) begin
                n_slice = i_cfg_data;
            end
        end

        if (i_cmd.latch_in) begin
            n_in = i_in_data;
        end

        // An arrival claims the lowest free slot and joins the ready tail.
        if (i_cmd.do_arrive && arr_ok) begin
            n_free[free_slot] = 1'b0;
            n_rc              = r_rc + 1'b1;
        end

        // Start of a tick: capture the running key and clear the results.
        if (i_cmd.cap_runkey) begin
            n_run_key = use_prio ? r_tbl_q.prio : r_tbl_q.cpu;
            n_run_arr = r_tbl_q.arr;
            n_idx     = '0;
            n_keep    = '0;
            n_done    = '0;
            n_res     = '0;
        end

        // Selection scan over the ready queue.
        if (i_cmd.scan_rdt || i_cmd.age_rdt) begin
            n_cur_slot = r_rq_q;
        end
        if (i_cmd.io_rdt) begin
            n_cur_slot = r_wq_q;
        end
        if (i_cmd.scan_cmp) begin
            if ((r_idx == '0) || cur_better) begin
                n_best_pos  = r_idx;
                n_best_slot = r_cur_slot;
                n_best_key  = cur_key;
                n_best_arr  = r_tbl_q.arr;
            end
            n_idx = idx_p1;
        end

        // Removal of the chosen entry and the switch of the running process.
        if (i_cmd.take_init) begin
            n_idx = r_best_pos;
        end
        if (i_cmd.shift_wr) begin
            n_idx = idx_p1;
        end
        if (i_cmd.take_fin) begin
            if (r_run_valid) begin
                n_res.preempted = 1'b1;
            end else begin
                n_rc = rc_m1;
            end
            n_run_slot   = r_best_slot;
            n_run_valid  = 1'b1;
            n_slice_used = 8'd0;
            n_idx        = '0;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end

        // Ageing of the ready entries.
        if (i_cmd.age_wr) begin
            n_idx = idx_p1;
        end

        // I/O countdown; finished entries go to the ready tail in order.
        if (i_cmd.io_wr) begin
            n_idx = idx_p1;
            if (io_fin) begin
                if (r_rc < N_C) begin
                    n_rc = r_rc + 1'b1;
                end
                if (r_done != 5'd31) begin
                    n_done = r_done + 5'd1;
                end
            end else begin
                n_keep = r_keep + 1'b1;
            end
        end
        if (i_cmd.io_end) begin
            n_wc                 = r_keep;
            n_res.io_completions = r_done;
        end

        // Run one unit, then retire or start I/O.
        if (i_cmd.run_wr) begin
            n_res.running_id = r_tbl_q.id;
            if (r_slice_used != 8'hFF) begin
                n_slice_used = r_slice_used + 8'd1;
            end
            if (run_fin) begin
                n_res.finished            = 1'b1;
                n_res.finished_id         = r_tbl_q.id;
                n_res.finished_wait       = r_tbl_q.wait_cnt;
                n_res.finished_turnaround = run_e.tat_cnt;
                n_free[r_run_slot]        = 1'b1;
                n_run_valid               = 1'b0;
            end else if (run_io) begin
                if (r_wc < N_C) begin
                    n_wc = r_wc + 1'b1;
                end
                n_res.io_started = 1'b1;
                n_run_valid      = 1'b0;
            end
        end

        // Result register: loads at the end of a tick, empties when taken.
        if (i_cmd.out_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
            n_tick      = r_tick + 16'd1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= mps_pkg::RST_MODE;
            r_slice      <= mps_pkg::RST_SLICE;
            r_rc         <= '0;
            r_wc         <= '0;
            r_run_valid  <= 1'b0;
            r_slice_used <= 8'd0;
            r_tick       <= 16'd0;
            r_free       <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_slice      <= n_slice;
            r_rc         <= n_rc;
            r_wc         <= n_wc;
            r_run_valid  <= n_run_valid;
            r_slice_used <= n_slice_used;
            r_tick       <= n_tick;
            r_free       <= n_free;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_run_slot  <= n_run_slot;
        r_idx       <= n_idx;
        r_keep      <= n_keep;
        r_best_pos  <= n_best_pos;
        r_done      <= n_done;
        r_cur_slot  <= n_cur_slot;
        r_best_slot <= n_best_slot;
        r_best_key  <= n_best_key;
        r_run_key   <= n_run_key;
        r_best_arr  <= n_best_arr;
        r_run_arr   <= n_run_arr;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // Status to the controller.
    always_comb begin
        o_stat.in_kind    = i_in_data.kind;
        o_stat.need_sel   = (r_rc != '0) && (!r_run_valid || preempt ||
                            (rr && (r_slice_used >= r_slice)));
        o_stat.scan_more  = (idx_p1 < limit);
        o_stat.take       = !r_run_valid || rr || (preempt && best_better_run);
        o_stat.shift_more = (idx_p1 < r_rc);
        o_stat.idx_lt_rc  = (r_idx < r_rc);
        o_stat.idx_lt_wc  = (r_idx < r_wc);
        o_stat.run_valid  = r_run_valid;
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> src/multi_policy_process_scheduler.sv
// Multi-policy process scheduler. An arrival transaction gives no result. A tick may
// select a new running process by scanning S ready entries and, when the chosen entry is
// taken, moving M queue entries up; it then ages the R ready entries, counts down the W
// waiting entries and runs the process, if there is one, each entry walked through the
// single registered read port of the table and queue memories. A stalled result holds
// the tick in its output state; one item at a time. Reset (synchronous, active low)
// empties both queues, frees every slot, clears the tick and restores the default policy
// and quantum; the table memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_policy_process_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire mps_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output mps_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mps_pkg::t_cmd  cmd;
    mps_pkg::t_stat stat;

    // Sequencer.
    mps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Table, queues and result register.
    mps_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_cfg_ready (o_cfg_ready)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the multi-policy process scheduler.
// Depends on mps_pkg and multi_policy_process_scheduler; predicts every tick result locally.
`timescale 1ns / 1ps

module testbench;

    localparam int NSLOT = 16;

    // Directed stimulus row; chk set means the typed result is compared as well.
    typedef struct {
        logic      cfg;
        logic [1:0] cidx;
        logic [7:0] cval;
        mps_pkg::t_in_item  item;
        logic      chk;
        mps_pkg::t_out_item res;
    } t_row;

    typedef struct {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [7:0]  cpu;
        logic [7:0]  io;
        logic [15:0] arr;
        logic [15:0] wt;
        logic [15:0] tat;
    } t_proc;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    mps_pkg::t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b1;
    mps_pkg::t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    multi_policy_process_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scheduler state mirrored by the predictor.
    t_proc       procs[NSLOT];
    int          rdy_q[$];
    int          io_q[$];
    bit          have_run;
    int          run_slot;
    int          quantum_used;
    logic [15:0] tick_cnt;
    bit [NSLOT-1:0] slot_free;
    logic [2:0]  sched_mode;
    logic [7:0]  quantum;

    mps_pkg::t_out_item expected_ticks[$];
    int          errors = 0;
    int          ticks_seen = 0;
    int          finishes_seen = 0;
    int          n_items = 0;
    bit          stim_done = 0;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit beats(int a, int b, bit by_prio);
        int ka, kb;
        ka = by_prio ? procs[a].prio : procs[a].cpu;
        kb = by_prio ? procs[b].prio : procs[b].cpu;
        if (ka != kb) return ka < kb;
        return procs[a].arr < procs[b].arr;
    endfunction

    function automatic int pick_best(bit by_prio);
        int b;
        b = 0;
        for (int i = 1; i < rdy_q.size(); i++)
            if (beats(rdy_q[i], rdy_q[b], by_prio)) b = i;
        return b;
    endfunction

    task automatic sched_reset();
        rdy_q.delete();
        io_q.delete();
        have_run = 0;
        run_slot = 0;
        quantum_used = 0;
        tick_cnt = '0;
        slot_free = '1;
        sched_mode = mps_pkg::RST_MODE;
        quantum = mps_pkg::RST_SLICE;
    endtask

    // Apply one accepted item to the mirror; ticks push an expected result.
    task automatic sched_step(input mps_pkg::t_in_item it);
        logic [2:0] m;
        bit was_run, by_prio, pre, io_go, fin;
        int was_slot, pos, nxt, done, s, slot;
        int keep[$];
        mps_pkg::t_out_item r;
        was_run = have_run;
        was_slot = run_slot;
        pre = 0; io_go = 0; fin = 0; done = 0;
        r = '0;
        if (!it.kind) begin
            if (it.proc_id == 0 || slot_free == 0) return;
            slot = 0;
            while (!slot_free[slot]) slot++;
            slot_free[slot] = 1'b0;
            procs[slot] = '{it.proc_id, it.prio_level, it.cpu_need, it.io_need,
                            tick_cnt, 16'd0, 16'd0};
            rdy_q.push_back(slot);
            return;
        end
        m = (sched_mode > mps_pkg::MODE_RR) ? mps_pkg::MODE_FCFS : sched_mode;
        // Selection of the running process.
        if (rdy_q.size() > 0) begin
            by_prio = (m == mps_pkg::MODE_PRIO || m == mps_pkg::MODE_PPRIO);
            if (!have_run) begin
                pos = (m == mps_pkg::MODE_FCFS || m == mps_pkg::MODE_RR) ? 0
                                                                         : pick_best(by_prio);
                run_slot = rdy_q[pos];
                rdy_q.delete(pos);
                have_run = 1;
            end else if (m == mps_pkg::MODE_PSJF || m == mps_pkg::MODE_PPRIO) begin
                pos = pick_best(by_prio);
                if (beats(rdy_q[pos], run_slot, by_prio)) begin
                    nxt = rdy_q[pos];
                    rdy_q.delete(pos);
                    rdy_q.push_back(run_slot);
                    run_slot = nxt;
                    pre = 1;
                end
            end else if (m == mps_pkg::MODE_RR && quantum_used >= quantum) begin
                nxt = rdy_q.pop_front();
                rdy_q.push_back(run_slot);
                run_slot = nxt;
                pre = 1;
            end
        end
        if (have_run != was_run || (have_run && run_slot != was_slot)) quantum_used = 0;
        // Ready entries age.
        foreach (rdy_q[i]) begin
            procs[rdy_q[i]].wt = sat_inc(procs[rdy_q[i]].wt);
            procs[rdy_q[i]].tat = sat_inc(procs[rdy_q[i]].tat);
        end
        // I/O waits count down; finished ones rejoin the ready tail.
        foreach (io_q[i]) begin
            s = io_q[i];
            procs[s].tat = sat_inc(procs[s].tat);
            if (procs[s].io > 0) procs[s].io--;
            if (procs[s].io == 0) begin
                rdy_q.push_back(s);
                done++;
            end else keep.push_back(s);
        end
        io_q = keep;
        // Run one unit, then retire or start I/O.
        if (have_run) begin
            r.running_id = procs[run_slot].id;
            if (procs[run_slot].cpu > 0) procs[run_slot].cpu--;
            procs[run_slot].tat = sat_inc(procs[run_slot].tat);
            if (quantum_used < 255) quantum_used++;
            if (procs[run_slot].cpu == 0) begin
                fin = 1;
                r.finished_id = procs[run_slot].id;
                r.finished_wait = procs[run_slot].wt;
                r.finished_turnaround = procs[run_slot].tat;
                slot_free[run_slot] = 1'b1;
                have_run = 0;
            end else if (procs[run_slot].io > 0 && it.io_request) begin
                io_q.push_back(run_slot);
                io_go = 1;
                have_run = 0;
            end
        end
        tick_cnt = tick_cnt + 16'd1;
        r.preempted = pre;
        r.io_started = io_go;
        r.io_completions = (done > 31) ? 5'd31 : done[4:0];
        r.finished = fin;
        expected_ticks.push_back(r);
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("mismatch on tick result %0d: %s got %0d expected %0d",
                 ticks_seen, what, got, exp);
        errors++;
    endtask

    // Result monitor: compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        mps_pkg::t_out_item e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_ticks.size() == 0) begin
                $display("unexpected result transaction %0d", ticks_seen);
                errors++;
            end else begin
                e = expected_ticks.pop_front();
                if (out_data.running_id != e.running_id)
                    report("running_id", 16'(out_data.running_id), 16'(e.running_id));
                if (out_data.preempted != e.preempted)
                    report("preempted", 16'(out_data.preempted), 16'(e.preempted));
                if (out_data.io_started != e.io_started)
                    report("io_started", 16'(out_data.io_started), 16'(e.io_started));
                if (out_data.io_completions != e.io_completions)
                    report("io_completions", 16'(out_data.io_completions),
                           16'(e.io_completions));
                if (out_data.finished != e.finished)
                    report("finished", 16'(out_data.finished), 16'(e.finished));
                if (out_data.finished_id != e.finished_id)
                    report("finished_id", 16'(out_data.finished_id), 16'(e.finished_id));
                if (out_data.finished_wait != e.finished_wait)
                    report("finished_wait", out_data.finished_wait, e.finished_wait);
                if (out_data.finished_turnaround != e.finished_turnaround)
                    report("finished_turnaround", out_data.finished_turnaround,
                           e.finished_turnaround);
                if (e.finished) finishes_seen++;
            end
            ticks_seen++;
        end
    end

    // Receiver: random stall lengths, with quiet stretches of no stalling.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // Valid stays up after an acceptance until the next falling edge, where the next
    // transaction either replaces it or a gap begins.
    task automatic send_item(input mps_pkg::t_in_item it, input bit gap_on);
        int n;
        n = gap_on ? $urandom_range(0, 17) : 0;
        @(negedge i_clk);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sched_step(it);
    endtask

    // Stop sending, wait for all results, then allow the worst-case tick latency.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        drain();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == mps_pkg::CFG_POLICY) sched_mode = val[2:0];
        else if (idx == mps_pkg::CFG_SLICE) quantum = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mps_pkg::t_in_item arrival(logic [7:0] id, logic [7:0] pr,
                                                  logic [7:0] c, logic [7:0] io);
        return '{1'b0, id, pr, c, io, 1'b0};
    endfunction

    function automatic mps_pkg::t_in_item tick(bit ioreq);
        mps_pkg::t_in_item t;
        t = '0;
        t.kind = 1'b1;
        t.io_request = ioreq;
        return t;
    endfunction

    function automatic mps_pkg::t_in_item random_arrival();
        return arrival($urandom_range(0, 255) == 0 ? 8'd0 : 8'($urandom_range(1, 255)),
                       8'($urandom_range(0, 255)),
                       ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 6)),
                       ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 4)));
    endfunction

    // Stimulus: directed table first, then random phases across the policies.
    initial begin
        t_row rows[$];
        t_row rw;
        mps_pkg::t_out_item e;
        logic [2:0] modes[8];
        logic [7:0] slices[8];

        for (int i = 0; i < NSLOT; i++) procs[i] = '{default: '0};
        sched_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle tick after reset, extremes of the fields, zero id, zero burst.
        rw = '{default: '0};
        rw.item = tick(1'b1); rw.chk = 1; rows.push_back(rw);
        rw.chk = 0;
        rw.item = arrival(8'd0, 8'd5, 8'd5, 8'd0); rows.push_back(rw);
        rw.item = arrival(8'd255, 8'd255, 8'd0, 8'd0); rows.push_back(rw);
        rw.item = tick(1'b0); rw.chk = 1;
        rw.res = '{8'd255, 1'b0, 1'b0, 5'd0, 1'b1, 8'd255, 16'd0, 16'd1};
        rows.push_back(rw);
        rw.chk = 0;
        rw.item = arrival(8'd1, 8'd0, 8'd255, 8'd255); rows.push_back(rw);
        rw.item = arrival(8'd2, 8'd0, 8'd1, 8'd1); rows.push_back(rw);
        rw.item = tick(1'b1); rows.push_back(rw);
        rw.item = tick(1'b1); rows.push_back(rw);
        // Unused mode code falls back to first come first served.
        rw.cfg = 1; rw.cidx = mps_pkg::CFG_POLICY; rw.cval = 8'd7; rows.push_back(rw);
        rw.cfg = 0;
        rw.item = tick(1'b0); rows.push_back(rw);
        rw.item = tick(1'b1); rows.push_back(rw);
        // Zero quantum makes round robin rotate on every tick.
        rw.cfg = 1; rw.cidx = mps_pkg::CFG_SLICE; rw.cval = 8'd0; rows.push_back(rw);
        rw.cidx = mps_pkg::CFG_POLICY; rw.cval = {5'd0, mps_pkg::MODE_RR}; rows.push_back(rw);
        rw.cfg = 0;
        rw.item = arrival(8'd3, 8'd9, 8'd3, 8'd0); rows.push_back(rw);
        rw.item = tick(1'b0); rows.push_back(rw);
        rw.item = tick(1'b0); rows.push_back(rw);
        rw.item = tick(1'b1); rows.push_back(rw);
        // Full table: one slot is held by a process in I/O, so of seventeen arrivals
        // the last two are ignored.
        for (int i = 0; i < 17; i++) begin
            rw.item = arrival(8'(i + 10), 8'(i), 8'd1, 8'd0);
            rows.push_back(rw);
        end
        rw.item = tick(1'b0); rows.push_back(rw);

        foreach (rows[i]) begin
            if (rows[i].cfg) write_reg(rows[i].cidx, rows[i].cval);
            else begin
                send_item(rows[i].item, 1'b1);
                if (rows[i].chk && rows[i].item.kind) begin
                    // The typed result replaces the predicted one for this row.
                    e = expected_ticks.pop_back();
                    if (e != rows[i].res) begin
                        $display("directed row %0d disagrees with hand-typed result", i);
                        errors++;
                    end
                    expected_ticks.push_back(rows[i].res);
                end
            end
        end

        // Random phases, each with a policy and quantum, extremes included.
        modes = '{mps_pkg::MODE_FCFS, mps_pkg::MODE_SJF, mps_pkg::MODE_PSJF,
                  mps_pkg::MODE_PRIO, mps_pkg::MODE_PPRIO, mps_pkg::MODE_RR,
                  mps_pkg::MODE_RR, 3'd6};
        slices = '{8'd1, 8'd3, 8'd255, 8'd2, 8'd1, 8'd1, 8'd255, 8'd4};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(mps_pkg::CFG_SLICE, slices[ph]);
            write_reg(mps_pkg::CFG_POLICY, {5'd0, modes[ph]});
            for (int k = 0; k < 45; k++) begin
                if (k == 25 && ph == 2) drain();
                if ($urandom_range(0, 99) < 35) send_item(random_arrival(), ph % 3 != 1);
                else send_item(tick(1'($urandom_range(0, 1))), ph % 3 != 1);
                n_items++;
            end
            // A few back-to-back ticks let the queued work move on before the policy changes.
            for (int k = 0; k < 8 && (have_run || rdy_q.size() || io_q.size()); k++) begin
                send_item(tick(1'b0), 1'b0);
                n_items++;
            end
        end

        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("covered %0d random items, %0d tick results and %0d retirements across",
                 n_items, ticks_seen, finishes_seen);
        $display("all six policies, both quantum extremes, a full table and a zero identifier");
        if (errors == 0 && expected_ticks.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout reached");
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/mps_pkg.sv
src/mps_ctrl.sv
src/mps_dpath.sv
src/multi_policy_process_scheduler.sv
test/testbench.sv
